/* rtl/chtbd_pkg.sv */
// ----------------------------------------------------------------------------
// chtbd_pkg
// Shared types and constants for the context Huffman tree builder/decoder.
// ----------------------------------------------------------------------------
package chtbd_pkg;

  localparam int unsigned NUM_TREES_DEF      = 256;
  localparam int unsigned NODES_PER_TREE_DEF = 512;
  localparam int unsigned SYM_W              = 8;
  localparam int unsigned NODE_FW            = 9;   // node fields in an entry
  localparam logic [SYM_W-1:0] END_RESET     = 8'h55;

  // One node table entry (28 bits)
  typedef struct packed {
    logic               hasr;
    logic               leaf;
    logic [NODE_FW-1:0] parent;
    logic [NODE_FW-1:0] right;
    logic [SYM_W-1:0]   sym;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             symbol_valid;
    logic             end_of_string;
    logic             tree_complete;
    logic             error;
  } result_t;

endpackage

/* rtl/chtbd_in_if.sv */
// ----------------------------------------------------------------------------
// chtbd_in_if
// Input item channel: shape bits and text bits.
// ----------------------------------------------------------------------------
interface chtbd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic                         data_bit;
  logic [chtbd_pkg::SYM_W-1:0]  tree_index;
  logic [chtbd_pkg::SYM_W-1:0]  leaf_symbol;
  logic                         string_start;

  modport source (output valid, cmd, data_bit, tree_index, leaf_symbol, string_start,
                  input ready);
  modport sink   (input valid, cmd, data_bit, tree_index, leaf_symbol, string_start,
                  output ready);
endinterface

/* rtl/chtbd_out_if.sv */
// ----------------------------------------------------------------------------
// chtbd_out_if
// Result item channel.
// ----------------------------------------------------------------------------
interface chtbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [chtbd_pkg::SYM_W-1:0]  symbol;
  logic                         symbol_valid;
  logic                         end_of_string;
  logic                         tree_complete;
  logic                         error;

  modport source (output valid, symbol, symbol_valid, end_of_string, tree_complete, error,
                  input ready);
  modport sink   (input valid, symbol, symbol_valid, end_of_string, tree_complete, error,
                  output ready);
endinterface

/* rtl/chtbd_cfg_if.sv */
// ----------------------------------------------------------------------------
// chtbd_cfg_if
// Configuration write channel for the end symbol register.
// ----------------------------------------------------------------------------
interface chtbd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [chtbd_pkg::SYM_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/chtbd_ram.sv */
// ----------------------------------------------------------------------------
// chtbd_ram
// Single-port node table memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module chtbd_ram #(
  parameter int unsigned DEPTH = chtbd_pkg::NUM_TREES_DEF * chtbd_pkg::NODES_PER_TREE_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               we_i,
  input  logic [AW-1:0]      addr_i,
  input  chtbd_pkg::entry_t  wdata_i,
  output chtbd_pkg::entry_t  rdata_o
);

  chtbd_pkg::entry_t mem [DEPTH];
  chtbd_pkg::entry_t rdata_q;

  // write or read; read data is registered and appears in the next cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/context_huffman_tree_builder_decoder.sv */
// ----------------------------------------------------------------------------
// context_huffman_tree_builder_decoder
// Per-context Huffman trees, built from pre-order shape bits and walked by
// text bits. All tree nodes live in one single-port node table.
// ----------------------------------------------------------------------------
// Items: a new input item is accepted only in idle, once the previous one is
// done; text steps are paced by the dependent node-table read per step on
// the single memory port.
// Reset: built flags clear, context = 0x55, end symbol = 0x55; the node
// table needs no clearing pass (entries are written before being read).
// ----------------------------------------------------------------------------
module context_huffman_tree_builder_decoder #(
  parameter int unsigned NUM_TREES      = chtbd_pkg::NUM_TREES_DEF,
  parameter int unsigned NODES_PER_TREE = chtbd_pkg::NODES_PER_TREE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chtbd_in_if.sink    in_i,
  chtbd_out_if.source out_o,
  chtbd_cfg_if.sink   cfg_i
);

  localparam int unsigned TW    = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
  localparam int unsigned NW    = $clog2(NODES_PER_TREE);
  localparam int unsigned DEPTH = NUM_TREES * NODES_PER_TREE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [NW:0] NPT   = (NW+1)'(NODES_PER_TREE);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES_PER_TREE - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_SHAPE, S_LEAF, S_RDP, S_PAR, S_CHILD, S_T1, S_T2, S_OUT
  } state_e;

  // address of a node within the flat table
  function automatic logic [AW-1:0] node_addr(input logic [TW-1:0] tree,
                                              input logic [NW-1:0] node);
    node_addr = AW'(int'(tree) * NODES_PER_TREE + int'(node));
  endfunction

  state_e                      state_q, state_d;
  logic [NUM_TREES-1:0]        built_q, built_d;
  logic                        active_q, active_d;
  logic [TW-1:0]               btree_q, btree_d;
  logic [NW-1:0]               bnode_q, bnode_d;
  logic [NW:0]                 free_q, free_d;
  logic [NW-1:0]               dnode_q, dnode_d;
  logic [chtbd_pkg::SYM_W-1:0] ctx_q, ctx_d;
  logic [chtbd_pkg::SYM_W-1:0] end_q;
  logic                        bit_q, bit_d;
  logic [chtbd_pkg::SYM_W-1:0] lsym_q, lsym_d;
  logic [NW-1:0]               cur_q, cur_d;
  logic [NW-1:0]               par_q, par_d;
  chtbd_pkg::entry_t           e_q, e_d;
  chtbd_pkg::result_t          res_q, res_d;
  chtbd_pkg::result_t          out_q;
  logic                        out_vld_q;

  logic                        ram_en, ram_we;
  logic [AW-1:0]               ram_addr;
  chtbd_pkg::entry_t           ram_wdata, ram_rdata;

  logic                        in_acc;
  logic [chtbd_pkg::SYM_W-1:0] tctx;
  logic [NW-1:0]               tnode, nxt;
  logic [NW-1:0]               pnode;
  chtbd_pkg::result_t          res_err, res_done, res_sym;

  chtbd_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid         = out_vld_q;
  assign out_o.symbol        = out_q.symbol;
  assign out_o.symbol_valid  = out_q.symbol_valid;
  assign out_o.end_of_string = out_q.end_of_string;
  assign out_o.tree_complete = out_q.tree_complete;
  assign out_o.error         = out_q.error;

  // text context and start node after a possible string start
  assign tctx  = in_i.string_start ? end_q : ctx_q;
  assign tnode = in_i.string_start ? '0 : dnode_q;
  assign pnode = e_q.parent[NW-1:0];

  // next node of a text step (left child is node + 1)
  always_comb begin
    if (bit_q) nxt = ram_rdata.right[NW-1:0];
    else       nxt = (dnode_q == LAST_NODE) ? '0 : dnode_q + 1'b1;
  end

  // canned results
  always_comb begin
    res_err  = '0;
    res_err.error = 1'b1;
    res_done = '0;
    res_done.tree_complete = 1'b1;
    res_sym  = '0;
    res_sym.symbol        = ram_rdata.sym;
    res_sym.symbol_valid  = 1'b1;
    res_sym.end_of_string = (ram_rdata.sym == end_q);
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    built_d  = built_q;
    active_d = active_q;
    btree_d  = btree_q;
    bnode_d  = bnode_q;
    free_d   = free_q;
    dnode_d  = dnode_q;
    ctx_d    = ctx_q;
    bit_d    = bit_q;
    lsym_d   = lsym_q;
    cur_d    = cur_q;
    par_d    = par_q;
    e_d      = e_q;
    res_d    = res_q;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = '0;
    ram_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          bit_d  = in_i.data_bit;
          lsym_d = in_i.leaf_symbol;
          if (!in_i.cmd) begin
            if (32'(in_i.tree_index) < NUM_TREES) begin
              if (!active_q) begin
                active_d = 1'b1;
                btree_d  = in_i.tree_index[TW-1:0];
                built_d[in_i.tree_index[TW-1:0]] = 1'b0;
                bnode_d  = '0;
                free_d   = (NW+1)'(1);
                dnode_d  = '0;
                state_d  = S_ROOT;
              end else if (in_i.tree_index[TW-1:0] == btree_q &&
                           in_i.tree_index == chtbd_pkg::SYM_W'(btree_q)) begin
                state_d = S_SHAPE;
              end
            end
          end else begin
            ctx_d   = tctx;
            dnode_d = tnode;
            if (32'(tctx) >= NUM_TREES || !built_q[tctx[TW-1:0]]) begin
              dnode_d = '0;
              res_d   = res_err;
              state_d = S_OUT;
            end else begin
              ram_en   = 1'b1;
              ram_addr = node_addr(tctx[TW-1:0], tnode);
              state_d  = S_T1;
            end
          end
        end
      end
      S_ROOT: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = node_addr(btree_q, '0);
        state_d  = S_SHAPE;
      end
      S_SHAPE: begin
        if (!bit_q) begin
          if (free_q >= NPT) begin
            active_d = 1'b0;
            res_d    = res_err;
            state_d  = S_OUT;
          end else begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = node_addr(btree_q, free_q[NW-1:0]);
            ram_wdata.parent = chtbd_pkg::NODE_FW'(bnode_q);
            bnode_d  = free_q[NW-1:0];
            free_d   = free_q + 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          ram_en   = 1'b1;
          ram_addr = node_addr(btree_q, bnode_q);
          cur_d    = bnode_q;
          state_d  = S_LEAF;
        end
      end
      S_LEAF: begin
        // mark the current node a leaf
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = node_addr(btree_q, cur_q);
        ram_wdata = ram_rdata;
        ram_wdata.sym  = lsym_q;
        ram_wdata.leaf = 1'b1;
        e_d = ram_rdata;
        if (cur_q == '0) begin
          built_d[btree_q] = 1'b1;
          active_d = 1'b0;
          bnode_d  = '0;
          res_d    = res_done;
          state_d  = S_OUT;
        end else begin
          state_d = S_RDP;
        end
      end
      S_RDP: begin
        ram_en   = 1'b1;
        ram_addr = node_addr(btree_q, pnode);
        state_d  = S_PAR;
      end
      S_PAR: begin
        // climb while the parent's right branch is taken
        if (ram_rdata.hasr) begin
          cur_d = pnode;
          e_d   = ram_rdata;
          if (pnode == '0) begin
            built_d[btree_q] = 1'b1;
            active_d = 1'b0;
            bnode_d  = '0;
            res_d    = res_done;
            state_d  = S_OUT;
          end else begin
            ram_en   = 1'b1;
            ram_addr = node_addr(btree_q, ram_rdata.parent[NW-1:0]);
          end
        end else if (free_q >= NPT) begin
          active_d = 1'b0;
          res_d    = res_err;
          state_d  = S_OUT;
        end else begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = node_addr(btree_q, pnode);
          ram_wdata = ram_rdata;
          ram_wdata.right = chtbd_pkg::NODE_FW'(free_q[NW-1:0]);
          ram_wdata.hasr  = 1'b1;
          par_d   = pnode;
          state_d = S_CHILD;
        end
      end
      S_CHILD: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = node_addr(btree_q, free_q[NW-1:0]);
        ram_wdata.parent = chtbd_pkg::NODE_FW'(par_q);
        bnode_d  = free_q[NW-1:0];
        free_d   = free_q + 1'b1;
        state_d  = S_IDLE;
      end
      S_T1: begin
        if (ram_rdata.leaf) begin
          dnode_d = '0;
          ctx_d   = ram_rdata.sym;
          res_d   = res_sym;
          state_d = S_OUT;
        end else begin
          ram_en   = 1'b1;
          ram_addr = node_addr(ctx_q[TW-1:0], nxt);
          dnode_d  = nxt;
          state_d  = S_T2;
        end
      end
      S_T2: begin
        if (ram_rdata.leaf) begin
          dnode_d = '0;
          ctx_d   = ram_rdata.sym;
          res_d   = res_sym;
          state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_vld_q || out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      built_q   <= '0;
      active_q  <= 1'b0;
      btree_q   <= '0;
      bnode_q   <= '0;
      free_q    <= (NW+1)'(1);
      dnode_q   <= '0;
      ctx_q     <= chtbd_pkg::END_RESET;
      end_q     <= chtbd_pkg::END_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      built_q  <= built_d;
      active_q <= active_d;
      btree_q  <= btree_d;
      bnode_q  <= bnode_d;
      free_q   <= free_d;
      dnode_q  <= dnode_d;
      ctx_q    <= ctx_d;
      if (cfg_i.valid) end_q <= cfg_i.data;
      if (state_q == S_OUT && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    lsym_q <= lsym_d;
    cur_q  <= cur_d;
    par_q  <= par_d;
    e_q    <= e_d;
    res_q  <= res_d;
    if (state_q == S_OUT && (!out_vld_q || out_o.ready)) out_q <= res_q;
  end

  // checks
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= NPT) else $error("free count beyond tree size");

  a_build_unbuilt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !built_q[btree_q]) else $error("tree in build marked built");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_OUT) else $error("result without sequencer");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !ram_we) else $error("write while accepting item");

endmodule

/* sim/context_huffman_tree_builder_decoder_tb.sv */
// ----------------------------------------------------------------------------
// context_huffman_tree_builder_decoder_tb
// Builds per-context code trees from pre-order shape bits and then decodes
// random text bits through them. Every accepted input item is run through an
// in-bench model of the trees. The model's results are queued and compared
// field by field against each result item. Runs under several idle/stall mixes
// and several end symbol settings, and includes a node overflow case.
// ----------------------------------------------------------------------------
module context_huffman_tree_builder_decoder_tb;

  localparam int unsigned NT   = chtbd_pkg::NUM_TREES_DEF;
  localparam int unsigned NPT  = chtbd_pkg::NODES_PER_TREE_DEF;
  localparam int unsigned QUIET_CYC = 700;  // longest leaf climb plus margin

  logic clk_i;
  logic rst_ni;

  chtbd_in_if  in_if ();
  chtbd_out_if out_if ();
  chtbd_cfg_if cfg_if ();

  context_huffman_tree_builder_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // model state of the trees and decoder
  chtbd_pkg::entry_t ntab [0:NT*NPT-1];
  bit              built [0:NT-1];
  int unsigned     build_node, free_cnt, build_tr, dec_node;
  bit              build_act;
  logic [7:0]      ctx_sym, end_sym;

  chtbd_pkg::result_t result_q [$];
  bit              shape_q [$];
  logic [7:0]      ctx_set [4];
  int              errors;
  int              in_idle, out_stall;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #40000000;
    $display("context_huffman_tree_builder_decoder_tb NOT OK");
    $finish;
  end

  // one step of the tree builder/decoder; returns 1 when a result is due
  function automatic bit decode_step(input logic c, input logic b, input logic [7:0] ti,
                                     input logic [7:0] ls, input logic ss,
                                     output chtbd_pkg::result_t r);
    int unsigned t, cur, p, nx;
    chtbd_pkg::entry_t e;
    r = '0;
    if (!c) begin
      if (!build_act) begin
        build_act  = 1'b1;
        build_tr   = 32'(ti);
        built[ti]  = 1'b0;
        build_node = 0;
        free_cnt   = 1;
        dec_node   = 0;
        ntab[ti*NPT] = '0;
      end else if (32'(ti) != build_tr) begin
        return 1'b0;
      end
      t   = build_tr;
      cur = build_node;
      if (!b) begin
        if (free_cnt >= NPT) begin
          build_act = 1'b0;
          r.error   = 1'b1;
          return 1'b1;
        end
        e = '0;
        e.parent = 9'(cur);
        ntab[t*NPT+free_cnt] = e;
        build_node = free_cnt;
        free_cnt++;
        return 1'b0;
      end
      // leaf: store symbol, climb to the nearest open right branch
      ntab[t*NPT+cur].sym  = ls;
      ntab[t*NPT+cur].leaf = 1'b1;
      while (cur != 0 && ntab[t*NPT+ntab[t*NPT+cur].parent].hasr)
        cur = 32'(ntab[t*NPT+cur].parent);
      if (cur == 0) begin
        built[t]   = 1'b1;
        build_act  = 1'b0;
        build_node = 0;
        r.tree_complete = 1'b1;
        return 1'b1;
      end
      if (free_cnt >= NPT) begin
        build_act = 1'b0;
        r.error   = 1'b1;
        return 1'b1;
      end
      p = 32'(ntab[t*NPT+cur].parent);
      ntab[t*NPT+p].right = 9'(free_cnt);
      ntab[t*NPT+p].hasr  = 1'b1;
      e = '0;
      e.parent = 9'(p);
      ntab[t*NPT+free_cnt] = e;
      build_node = free_cnt;
      free_cnt++;
      return 1'b0;
    end
    // text bit
    if (ss) begin
      ctx_sym  = end_sym;
      dec_node = 0;
    end
    t = 32'(ctx_sym);
    if (!built[t]) begin
      dec_node = 0;
      r.error  = 1'b1;
      return 1'b1;
    end
    e = ntab[t*NPT+dec_node];
    if (e.leaf) begin
      nx = dec_node;
    end else begin
      nx = b ? 32'(e.right) : (dec_node + 1) % NPT;
      e  = ntab[t*NPT+nx];
    end
    if (!e.leaf) begin
      dec_node = nx;
      return 1'b0;
    end
    dec_node = 0;
    ctx_sym  = e.sym;
    r.symbol = e.sym;
    r.symbol_valid  = 1'b1;
    r.end_of_string = (e.sym == end_sym);
    return 1'b1;
  endfunction

  // pre-order shape of a random full tree with the given leaf count
  function automatic void gen_shape(input int leaves);
    int k;
    if (leaves <= 1) begin
      shape_q.push_back(1'b1);
    end else begin
      shape_q.push_back(1'b0);
      k = $urandom_range(leaves - 1, 1);
      gen_shape(k);
      gen_shape(leaves - k);
    end
  endfunction

  // send one input item, model it on acceptance
  task automatic send_item(input logic c, input logic b, input logic [7:0] ti,
                           input logic [7:0] ls, input logic ss);
    chtbd_pkg::result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= c;
    in_if.data_bit     <= b;
    in_if.tree_index   <= ti;
    in_if.leaf_symbol  <= ls;
    in_if.string_start <= ss;
    do @(posedge clk_i); while (!in_if.ready);
    if (decode_step(c, b, ti, ls, ss, r)) result_q.push_back(r);
  endtask

  // drop valid and wait for all results plus the longest quiet work
  task automatic wait_quiet();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYC) @(posedge clk_i);
  endtask

  task automatic write_end_symbol(input logic [7:0] v);
    wait_quiet();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    end_sym = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // build a well-formed tree with leaves drawn from the context set
  task automatic build_tree(input logic [7:0] ti, input int leaves);
    shape_q.delete();
    gen_shape(leaves);
    foreach (shape_q[i])
      send_item(1'b0, shape_q[i], ti, ctx_set[$urandom_range(3)], 1'($urandom_range(1)));
  endtask

  task automatic send_text(input logic b, input logic ss);
    send_item(1'b1, b, 8'($urandom_range(255)), 8'($urandom_range(255)), ss);
  endtask

  // result checker
  always @(posedge clk_i) begin
    chtbd_pkg::result_t exp_r;
    if (out_if.valid && out_if.ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result sym=%h v=%b eos=%b done=%b err=%b", $time,
                 out_if.symbol, out_if.symbol_valid, out_if.end_of_string,
                 out_if.tree_complete, out_if.error);
        errors++;
      end else begin
        exp_r = result_q.pop_front();
        if (out_if.symbol !== exp_r.symbol || out_if.symbol_valid !== exp_r.symbol_valid ||
            out_if.end_of_string !== exp_r.end_of_string ||
            out_if.tree_complete !== exp_r.tree_complete || out_if.error !== exp_r.error) begin
          $display("%0t: mismatch exp sym=%h v=%b eos=%b done=%b err=%b", $time,
                   exp_r.symbol, exp_r.symbol_valid, exp_r.end_of_string,
                   exp_r.tree_complete, exp_r.error);
          $display("%0t:          act sym=%h v=%b eos=%b done=%b err=%b", $time,
                   out_if.symbol, out_if.symbol_valid, out_if.end_of_string,
                   out_if.tree_complete, out_if.error);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i)
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= out_stall);

  // unbuilt context, single-leaf tree, ignored other-tree bits, extremes
  task automatic test_directed();
    send_text(1'b0, 1'b1);                         // unbuilt tree error
    send_item(1'b0, 1'b1, 8'h55, 8'h55, 1'b0);     // leaf root tree
    send_text(1'b1, 1'b0);
    send_text(1'b0, 1'b1);
    send_item(1'b0, 1'b0, 8'hFF, 8'h00, 1'b0);     // start build of tree FF
    send_item(1'b0, 1'b1, 8'h00, 8'hAA, 1'b1);     // other tree, ignored
    send_item(1'b0, 1'b1, 8'hFF, 8'h00, 1'b0);
    send_item(1'b0, 1'b1, 8'hFF, 8'hFF, 1'b0);     // completes FF
    send_item(1'b0, 1'b0, 8'h00, 8'h00, 1'b0);     // tree 00: leaves FF, 55
    send_item(1'b0, 1'b1, 8'h00, 8'hFF, 1'b0);
    send_item(1'b0, 1'b1, 8'h00, 8'h55, 1'b0);
    send_item(1'b0, 1'b0, 8'h55, 8'h00, 1'b0);     // tree 55: leaves 00, FF
    send_item(1'b0, 1'b1, 8'h55, 8'h00, 1'b0);
    send_item(1'b0, 1'b1, 8'h55, 8'hFF, 1'b0);
    send_text(1'b0, 1'b1);                         // -> 00
    send_text(1'b0, 1'b0);                         // -> FF
    send_text(1'b1, 1'b0);                         // -> FF
    send_text(1'b0, 1'b0);                         // -> 00
    send_text(1'b1, 1'b0);                         // -> 55, end of string
    send_text(1'b1, 1'b0);                         // -> FF
    send_text(1'b1, 1'b1);                         // restart -> FF
  endtask

  // left chain that uses the last node, then a leaf needing one node too many
  task automatic test_overflow();
    repeat (NPT - 2) send_item(1'b0, 1'b0, 8'h33, 8'h00, 1'b0);
    send_item(1'b0, 1'b1, 8'h33, 8'h12, 1'b0);     // last node taken as right child
    send_item(1'b0, 1'b1, 8'h33, 8'h34, 1'b0);     // climbs one level, no node left
    send_item(1'b1, 1'b0, 8'h00, 8'h00, 1'b1);     // text through tree 55 after the abort
  endtask

  // random decoding over a small set of contexts, with rebuilds and noise
  task automatic test_random(input logic [7:0] es, input int n_items);
    int k;
    write_end_symbol(es);
    ctx_set[0] = es;
    for (int i = 1; i < 4; i++) ctx_set[i] = 8'($urandom_range(255));
    foreach (ctx_set[i]) build_tree(ctx_set[i], $urandom_range(4, 1));
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(99);
      if (k < 78) begin
        send_text(1'($urandom_range(1)), $urandom_range(19) == 0);
      end else if (k < 93) begin
        build_tree(ctx_set[$urandom_range(3)],
                   ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(4, 1));
      end else if (k < 97) begin
        // aborted build: a few shape bits, never finished
        repeat ($urandom_range(3, 1))
          send_item(1'b0, 1'b0, ctx_set[$urandom_range(3)], 8'($urandom_range(255)), 1'b0);
        build_tree(build_tr[7:0], 1);
      end else begin
        send_item(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      if (i == n_items / 2 && es == 8'hFF) wait_quiet();  // sender holds off once
    end
  endtask

  initial begin
    errors    = 0;
    in_idle   = 0;
    out_stall = 0;
    build_node = 0;
    free_cnt   = 1;
    build_act  = 1'b0;
    build_tr   = 0;
    dec_node   = 0;
    end_sym    = chtbd_pkg::END_RESET;
    ctx_sym    = chtbd_pkg::END_RESET;
    foreach (built[i]) built[i] = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = 1'b0;
    in_if.data_bit = 1'b0;
    in_if.tree_index = '0;
    in_if.leaf_symbol = '0;
    in_if.string_start = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_overflow();
    test_random(8'h00, 12);
    in_idle = 77;
    test_random(8'hFF, 12);
    in_idle = 0;
    out_stall = 77;
    test_random(8'h55, 12);
    in_idle = 27;
    out_stall = 27;
    test_random(8'($urandom_range(255)), 12);

    wait_quiet();
    if (errors == 0)
      $display("context_huffman_tree_builder_decoder_tb OK");
    else
      $display("context_huffman_tree_builder_decoder_tb NOT OK");
    $finish;
  end

endmodule
